// File: hdl/assert_macros.svh
// Assertion macros shared by the governor RTL.
// Define ASSERT_OFF to compile the assertions away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	`ASSERT_PROP(label, clk, rst_n, !(expr))
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: hdl/sag_pkg.sv
`timescale 1ns / 1ps
package sag_pkg;
	localparam int TOTAL_WIDTH = 48;
	localparam int COUNT_WIDTH = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int MIN_W = 16;
	localparam int RATIO_W = 17;
	localparam int FRAC_STEPS = 16;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 17;

	localparam logic [MIN_W-1:0] DEFAULT_MIN = 16'd32;
	localparam logic [RATIO_W-1:0] DEFAULT_THRESH = 17'd22938;
	localparam logic [RATIO_W-1:0] ONE_Q16 = 17'd65536;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MIN_PROPOSALS = 1'b0,
		REG_THRESHOLD = 1'b1
	} sag_reg_t;

	typedef enum logic [1:0] {
		STATUS_RECORDED = 2'd0,
		STATUS_DISABLED = 2'd1,
		STATUS_INVALID = 2'd2
	} sag_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPDATE,
		S_DIVIDE,
		S_REPORT
	} sag_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sag_qstat_t;
endpackage

// File: hdl/sag_in_if.sv
`timescale 1ns / 1ps
interface sag_in_if #(
	parameter int COUNT_WIDTH = sag_pkg::COUNT_WIDTH
) ();
	logic valid;
	logic ready;
	logic [COUNT_WIDTH-1:0] proposed_count;
	logic [COUNT_WIDTH-1:0] accepted_count;

	modport source(output valid, proposed_count, accepted_count, input ready);
	modport sink(input valid, proposed_count, accepted_count, output ready);
endinterface

// File: hdl/sag_out_if.sv
`timescale 1ns / 1ps
interface sag_out_if #(
	parameter int TOTAL_WIDTH = sag_pkg::TOTAL_WIDTH
) ();
	logic valid;
	logic ready;
	logic [1:0] status;
	logic still_enabled;
	logic just_disabled;
	logic [sag_pkg::RATIO_W-1:0] acceptance_q16;
	logic [TOTAL_WIDTH-1:0] round_total;
	logic [TOTAL_WIDTH-1:0] proposed_total;
	logic [TOTAL_WIDTH-1:0] accepted_total;

	modport source(output valid, status, still_enabled, just_disabled, acceptance_q16,
		round_total, proposed_total, accepted_total, input ready);
	modport sink(input valid, status, still_enabled, just_disabled, acceptance_q16,
		round_total, proposed_total, accepted_total, output ready);
endinterface

// File: hdl/sag_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sag_queue #(
	parameter int WIDTH = 2 * sag_pkg::COUNT_WIDTH + 1,
	parameter int DEPTH = sag_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] push_item,
	input logic pop,
	output logic [WIDTH-1:0] pop_item,
	output sag_pkg::sag_qstat_t qstat
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign qstat.full = (count_q == FULL_CNT);
	assign qstat.empty = (count_q == '0);
	assign do_push = push && !qstat.full;
	assign do_pop = pop && !qstat.empty;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`ASSERT_NEVER(a_no_push_when_full, clk, arst_n, push && qstat.full)
	`ASSERT_NEVER(a_no_pop_when_empty, clk, arst_n, pop && qstat.empty)
endmodule

// File: hdl/sag_front.sv
`timescale 1ns / 1ps
module sag_front #(
	parameter int COUNT_WIDTH = sag_pkg::COUNT_WIDTH
) (
	input logic clk,
	input logic arst_n,
	sag_in_if.sink report,
	input sag_pkg::sag_qstat_t qstat,
	output logic push,
	output logic [2*COUNT_WIDTH:0] push_item
);
	logic vld_s1;
	logic [COUNT_WIDTH-1:0] prop_s1;
	logic [COUNT_WIDTH-1:0] acc_s1;
	logic accept;
	logic invalid;

	assign push = vld_s1 && !qstat.full;
	assign report.ready = !vld_s1 || push;
	assign accept = report.valid && report.ready;

	// A round with nothing proposed, or more accepted than proposed, is not counted.
	assign invalid = (prop_s1 == '0) || (acc_s1 > prop_s1);
	assign push_item = {prop_s1, acc_s1, invalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prop_s1 <= report.proposed_count;
			acc_s1 <= report.accepted_count;
		end
	end
endmodule

// File: hdl/sag_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sag_back #(
	parameter int TOTAL_WIDTH = sag_pkg::TOTAL_WIDTH,
	parameter int COUNT_WIDTH = sag_pkg::COUNT_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input sag_pkg::sag_qstat_t qstat,
	input logic [2*COUNT_WIDTH:0] pop_item,
	output logic pop,
	input logic [sag_pkg::MIN_W-1:0] min_proposals,
	input logic [sag_pkg::RATIO_W-1:0] threshold,
	sag_out_if.source result
);
	localparam int TW = TOTAL_WIDTH;
	localparam int RW = sag_pkg::RATIO_W;
	localparam int STEP_W = $clog2(sag_pkg::FRAC_STEPS + 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(sag_pkg::FRAC_STEPS);

	sag_pkg::sag_state_t state_q;
	sag_pkg::sag_state_t state_d;
	sag_pkg::sag_status_t status_q;

	logic [COUNT_WIDTH-1:0] prop_q;
	logic [COUNT_WIDTH-1:0] acc_q;
	logic invalid_q;
	logic en_q;
	logic [TW-1:0] rounds_q;
	logic [TW-1:0] props_q;
	logic [TW-1:0] accs_q;
	logic [TW-1:0] rem_q;
	logic [RW-1:0] quo_q;
	logic [STEP_W-1:0] step_q;

	logic out_vld_q;
	logic [1:0] out_status_q;
	logic out_en_q;
	logic out_just_q;
	logic [RW-1:0] out_ratio_q;
	logic [TW-1:0] out_rounds_q;
	logic [TW-1:0] out_props_q;
	logic [TW-1:0] out_accs_q;

	logic load_out;
	logic [TW:0] rounds_sum;
	logic [TW:0] props_sum;
	logic [TW:0] accs_sum;
	logic [TW:0] num;
	logic [TW:0] den;
	logic [TW:0] diff;
	logic ge;
	logic [RW-1:0] ratio;
	logic trip;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sag_pkg::S_IDLE: begin
				if (!qstat.empty) begin
					state_d = sag_pkg::S_UPDATE;
				end
			end
			sag_pkg::S_UPDATE: begin
				state_d = sag_pkg::S_DIVIDE;
			end
			sag_pkg::S_DIVIDE: begin
				if (step_q == LAST_STEP) begin
					state_d = sag_pkg::S_REPORT;
				end
			end
			sag_pkg::S_REPORT: begin
				if (load_out) begin
					state_d = sag_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sag_pkg::S_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		pop = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			sag_pkg::S_IDLE: begin
				pop = !qstat.empty;
			end
			sag_pkg::S_REPORT: begin
				load_out = !out_vld_q || result.ready;
			end
			default: begin
				pop = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	// Saturating totals: a carry out of the top bit means the sum passed the maximum.
	assign rounds_sum = {1'b0, rounds_q} + (TW + 1)'(1);
	assign props_sum = {1'b0, props_q} + (TW + 1)'(prop_q);
	assign accs_sum = {1'b0, accs_q} + (TW + 1)'(acc_q);

	// One restoring step per cycle; the first step yields the integer bit.
	assign den = {1'b0, props_q};
	assign num = (step_q == '0) ? {1'b0, accs_q} : {rem_q, 1'b0};
	assign diff = num - den;
	assign ge = (num >= den);

	always_comb begin
		if (props_q == '0) begin
			ratio = '0;
		end else if (quo_q > sag_pkg::ONE_Q16) begin
			ratio = sag_pkg::ONE_Q16;
		end else begin
			ratio = quo_q;
		end
	end

	assign trip = (status_q == sag_pkg::STATUS_RECORDED) &&
		(props_q >= TW'(min_proposals)) && (ratio < threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sag_pkg::S_IDLE;
			en_q <= 1'b1;
			rounds_q <= '0;
			props_q <= '0;
			accs_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sag_pkg::S_UPDATE && en_q && !invalid_q) begin
				rounds_q <= rounds_sum[TW] ? '1 : rounds_sum[TW-1:0];
				props_q <= props_sum[TW] ? '1 : props_sum[TW-1:0];
				accs_q <= accs_sum[TW] ? '1 : accs_sum[TW-1:0];
			end
			if (load_out) begin
				en_q <= en_q && !trip;
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			{prop_q, acc_q, invalid_q} <= pop_item;
		end
		if (state_q == sag_pkg::S_UPDATE) begin
			step_q <= '0;
			if (!en_q) begin
				status_q <= sag_pkg::STATUS_DISABLED;
			end else if (invalid_q) begin
				status_q <= sag_pkg::STATUS_INVALID;
			end else begin
				status_q <= sag_pkg::STATUS_RECORDED;
			end
		end
		if (state_q == sag_pkg::S_DIVIDE) begin
			step_q <= step_q + STEP_W'(1);
			quo_q <= (step_q == '0) ? RW'(ge) : {quo_q[RW-2:0], ge};
			rem_q <= ge ? diff[TW-1:0] : num[TW-1:0];
		end
		if (load_out) begin
			out_status_q <= status_q;
			out_en_q <= en_q && !trip;
			out_just_q <= trip;
			out_ratio_q <= ratio;
			out_rounds_q <= rounds_q;
			out_props_q <= props_q;
			out_accs_q <= accs_q;
		end
	end

	assign result.valid = out_vld_q;
	assign result.status = out_status_q;
	assign result.still_enabled = out_en_q;
	assign result.just_disabled = out_just_q;
	assign result.acceptance_q16 = out_ratio_q;
	assign result.round_total = out_rounds_q;
	assign result.proposed_total = out_props_q;
	assign result.accepted_total = out_accs_q;

	`ASSERT_PROP(a_disable_sticky, clk, arst_n, !en_q |=> !en_q)
	`ASSERT_NEVER(a_acc_within_prop, clk, arst_n, accs_q > props_q)
	`ASSERT_PROP(a_totals_move_in_update, clk, arst_n, (state_q != sag_pkg::S_UPDATE) |=> $stable(props_q))
	`ASSERT_PROP(a_just_means_off, clk, arst_n, (result.valid && result.just_disabled) |-> (!result.still_enabled && result.status == sag_pkg::STATUS_RECORDED))
endmodule

// File: hdl/speculation_acceptance_governor.sv
`timescale 1ns / 1ps
// Speculation acceptance governor.
// The report channel takes one word per decoding round: draft tokens proposed
// and accepted. The result channel returns one word per report with the status,
// the enable flag, whether this round switched speculation off, the running
// totals and the acceptance ratio in Q1.16.
// The configuration port writes the minimum proposal total and the disable
// threshold; a value of zero, or a threshold above 1.0, selects the built-in default.
// A report is registered and classified in the front stage, then waits in a
// two-entry queue for the back end, which updates the totals and divides with
// a restoring divider that resolves one quotient bit per cycle.
// A taken report passes the front register, the queue, the update state, the 17
// divider steps and the report state; the back end takes one report at a time.
// Up to three further reports are taken while the back end is busy.
// Reset enables speculation, clears the totals and loads the default registers.
// While the receiver stalls, the result word is held and the back end waits
// with the next finished word; the queue and front stage keep accepting until full.
module speculation_acceptance_governor #(
	parameter int TOTAL_WIDTH = sag_pkg::TOTAL_WIDTH,
	parameter int COUNT_WIDTH = sag_pkg::COUNT_WIDTH
) (
	input logic clk,
	input logic arst_n,
	sag_in_if.sink report,
	sag_out_if.source result,
	input logic cfg_we,
	input logic [sag_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [sag_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int ITEM_W = 2 * COUNT_WIDTH + 1;

	logic [sag_pkg::MIN_W-1:0] min_q;
	logic [sag_pkg::RATIO_W-1:0] thresh_q;
	logic [sag_pkg::MIN_W-1:0] min_val;
	logic [sag_pkg::RATIO_W-1:0] thresh_val;

	sag_pkg::sag_qstat_t qstat;
	logic push;
	logic pop;
	logic [ITEM_W-1:0] push_item;
	logic [ITEM_W-1:0] pop_item;

	assign min_val = cfg_data[sag_pkg::MIN_W-1:0];
	assign thresh_val = cfg_data[sag_pkg::RATIO_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= sag_pkg::DEFAULT_MIN;
			thresh_q <= sag_pkg::DEFAULT_THRESH;
		end else if (cfg_we) begin
			unique case (sag_pkg::sag_reg_t'(cfg_index))
				sag_pkg::REG_MIN_PROPOSALS: begin
					min_q <= (min_val == '0) ? sag_pkg::DEFAULT_MIN : min_val;
				end
				sag_pkg::REG_THRESHOLD: begin
					thresh_q <= (thresh_val == '0 || thresh_val > sag_pkg::ONE_Q16) ?
						sag_pkg::DEFAULT_THRESH : thresh_val;
				end
				default: begin
					min_q <= min_q;
				end
			endcase
		end
	end

	sag_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.report(report),
		.qstat(qstat),
		.push(push),
		.push_item(push_item)
	);

	sag_queue #(
		.WIDTH(ITEM_W),
		.DEPTH(sag_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.pop_item(pop_item),
		.qstat(qstat)
	);

	sag_back #(
		.TOTAL_WIDTH(TOTAL_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.pop_item(pop_item),
		.pop(pop),
		.min_proposals(min_q),
		.threshold(thresh_q),
		.result(result)
	);
endmodule
